/* hdl/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the NAND page access sequencer
// Geometry, command codes, result kinds and the sequencer state record.
// ----------------------------------------------------------------------------
package nps_pkg;

  // flash geometry
  localparam int PAGE_BYTES  = 2048;
  localparam int BLOCK_BYTES = 131072;
  localparam int ID_BYTES    = 5;
  localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
  localparam int BLOCK_BITS  = $clog2(BLOCK_BYTES);
  localparam int COL_W       = PAGE_BITS;
  localparam int ROW_W       = 24;
  localparam int IDC_W       = 3;
  localparam logic [ROW_W-1:0] BLOCK_PAGES = ROW_W'(BLOCK_BYTES / PAGE_BYTES);
  localparam logic [COL_W-1:0] COL_LAST    = COL_W'(PAGE_BYTES - 1);

  // result batch sizing
  localparam int NRES   = 9;
  localparam int RIDX_W = $clog2(NRES);
  localparam int CNT_W  = $clog2(NRES + 1);

  // request modes
  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_ERASE  = 3'd2;
  localparam logic [2:0] MODE_ID     = 3'd3;
  localparam logic [2:0] MODE_WBYTE  = 3'd4;
  localparam logic [2:0] MODE_FBYTE  = 3'd5;
  localparam logic [2:0] MODE_READY  = 3'd6;

  // NAND commands
  localparam logic [7:0] CMD_READ1  = 8'h00;
  localparam logic [7:0] CMD_READ2  = 8'h30;
  localparam logic [7:0] CMD_PROG1  = 8'h80;
  localparam logic [7:0] CMD_PROG2  = 8'h10;
  localparam logic [7:0] CMD_ERASE1 = 8'h60;
  localparam logic [7:0] CMD_ERASE2 = 8'hD0;
  localparam logic [7:0] CMD_RDID   = 8'h90;
  localparam logic [7:0] ADDR_ID    = 8'h00;

  // error codes
  localparam logic [7:0] ERR_ADDR  = 8'd0;
  localparam logic [7:0] ERR_LEN   = 8'd1;
  localparam logic [7:0] ERR_PHASE = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_RDATA, PH_WDATA, PH_IDDATA
  } phase_t;

  typedef enum logic [1:0] {
    OP_READ, OP_WRITE, OP_ERASE, OP_ID
  } op_t;

  typedef enum logic [3:0] {
    K_EN, K_DIS, K_CMD, K_ADDR, K_WDATA, K_STROBE, K_WAIT, K_HOST, K_ERR, K_DONE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } res_t;

  typedef struct packed {
    phase_t           phase;
    op_t              op;
    logic [ROW_W-1:0] page;
    logic [COL_W-1:0] col;
    logic [31:0]      left;
    logic [IDC_W-1:0] idc;
  } seq_st_t;

endpackage

/* hdl/nps_if.sv */
// ----------------------------------------------------------------------------
// nps_in_if / nps_out_if: request and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface nps_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] address;
  logic [31:0] length;
  logic [7:0]  data;

  modport source (output valid, mode, address, length, data, input ready);
  modport sink   (input valid, mode, address, length, data, output ready);
endinterface

interface nps_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cycle_kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, cycle_kind, value, last, input ready);
  modport sink   (input valid, cycle_kind, value, last, output ready);
endinterface

/* hdl/nand_page_access_sequencer.sv */
// ----------------------------------------------------------------------------
// nand_page_access_sequencer: large-page NAND command sequencer
// Turns host requests and flash events into a stream of NAND bus cycles.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries request words: start read/write/erase/read-id, host write
//          bytes, bytes read from flash and flash-ready events.
//   out_ch carries bus-cycle words (enable, disable, command, address,
//          data, strobe, wait-ready, host data, error, done); last marks
//          the final word caused by one request.
//   Each request word yields 1 to 9 result words. The first appears the
//   cycle after the request is taken; the rest follow one per cycle while
//   out_ch is ready. The result buffer holds one request's batch; the next
//   request is taken in the same cycle as the previous batch's last word.
//   When out_ch stalls the current word holds and in_ch.ready stays low
//   until the last word of the batch is taken.
//   Reset (synchronous, rst_n low) empties the buffer and returns the
//   sequencer to idle with cleared address, length and ID counters.
//   A word that the current phase does not expect yields one error word
//   (code 2) and leaves the state unchanged.
// ----------------------------------------------------------------------------
module nand_page_access_sequencer (
  input  logic      clk,
  input  logic      rst_n,
  nps_in_if.sink    in_ch,
  nps_out_if.source out_ch
);
  import nps_pkg::*;

  seq_st_t               st_r, st_nxt;
  res_t [NRES-1:0]       buf_r, res_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [RIDX_W-1:0]     idx_r;
  logic                  out_last, out_fire, in_fire;
  res_t                  cur;

  nps_step u_step (
    .st_cur  (st_r),
    .mode    (in_ch.mode),
    .address (in_ch.address),
    .length  (in_ch.length),
    .data    (in_ch.data),
    .st_nxt  (st_nxt),
    .res     (res_nxt),
    .res_cnt (cnt_nxt)
  );

  // present the current word of the batch
  assign cur               = buf_r[idx_r];
  assign out_last          = (CNT_W'(idx_r) == CNT_W'(cnt_r - 1'b1));
  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.cycle_kind = cur.kind;
  assign out_ch.value      = cur.value;
  assign out_ch.last       = out_last;
  assign out_fire          = out_ch.valid && out_ch.ready;

  // take a request when the buffer is empty or drains this cycle
  assign in_ch.ready = (cnt_r == '0) || (out_fire && out_last);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // load a new batch and advance the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= PH_IDLE;
      st_r.op    <= OP_READ;
      st_r.page  <= '0;
      st_r.col   <= '0;
      st_r.left  <= '0;
      st_r.idc   <= '0;
      cnt_r      <= '0;
      idx_r      <= '0;
    end else if (in_fire) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= '0;
    end else if (out_fire) begin
      if (out_last) begin
        cnt_r <= '0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // hold the batch payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_r <= res_nxt;
    end
  end

endmodule

/* hdl/nps_step.sv */
// ----------------------------------------------------------------------------
// nps_step: per-word decode of the sequencer
// From the current state and one request word, form the next state and the
// batch of bus cycles that the word causes.
// ----------------------------------------------------------------------------
module nps_step (
  input  nps_pkg::seq_st_t                  st_cur,
  input  logic [2:0]                        mode,
  input  logic [31:0]                       address,
  input  logic [31:0]                       length,
  input  logic [7:0]                        data,
  output nps_pkg::seq_st_t                  st_nxt,
  output nps_pkg::res_t [nps_pkg::NRES-1:0] res,
  output logic [nps_pkg::CNT_W-1:0]         res_cnt
);
  import nps_pkg::*;

  logic                  is_idle;
  logic                  s_rd, s_wr, s_er, s_id;
  logic                  w_rdy, r_dat, w_dat, i_dat;
  logic                  len_zero, addr_mis, len_mis;
  logic [31:0]           addr_pg;
  logic [31:0]           left_dec, left_blk;
  logic                  col_wrap;
  logic                  id_end;
  logic [IDC_W:0]        idc_inc;
  logic [15:0]           col_ext;
  logic [ROW_W-1:0]      page_inc;

  // decode the word against the phase
  assign is_idle = (st_cur.phase == PH_IDLE);
  assign s_rd    = is_idle && (mode == MODE_READ);
  assign s_wr    = is_idle && (mode == MODE_WRITE);
  assign s_er    = is_idle && (mode == MODE_ERASE);
  assign s_id    = is_idle && (mode == MODE_ID);
  assign w_rdy   = (st_cur.phase == PH_WAIT)   && (mode == MODE_READY);
  assign r_dat   = (st_cur.phase == PH_RDATA)  && (mode == MODE_FBYTE);
  assign w_dat   = (st_cur.phase == PH_WDATA)  && (mode == MODE_WBYTE);
  assign i_dat   = (st_cur.phase == PH_IDDATA) && (mode == MODE_FBYTE);

  assign len_zero = (length == 32'd0);
  assign addr_mis = (address[BLOCK_BITS-1:0] != '0);
  assign len_mis  = (length[BLOCK_BITS-1:0] != '0);
  assign addr_pg  = address >> PAGE_BITS;
  assign left_dec = st_cur.left - 32'd1;
  assign left_blk = st_cur.left - 32'(BLOCK_BYTES);
  assign col_wrap = (st_cur.col == COL_LAST);
  assign idc_inc  = {1'b0, st_cur.idc} + (IDC_W+1)'(1);
  assign id_end   = (idc_inc >= (IDC_W+1)'(ID_BYTES));
  assign page_inc = st_cur.page + ROW_W'(1);

  // next state
  always_comb begin
    st_nxt = st_cur;
    if (s_rd || s_wr || s_er || s_id) begin
      st_nxt.page = addr_pg[ROW_W-1:0];
      st_nxt.col  = address[COL_W-1:0];
      st_nxt.left = length;
    end
    if (s_rd) begin
      st_nxt.op    = OP_READ;
      st_nxt.phase = len_zero ? PH_IDLE : PH_WAIT;
    end else if (s_wr) begin
      st_nxt.op    = OP_WRITE;
      st_nxt.phase = len_zero ? PH_WAIT : PH_WDATA;
    end else if (s_er) begin
      st_nxt.op    = OP_ERASE;
      st_nxt.phase = (addr_mis || len_mis || len_zero) ? PH_IDLE : PH_WAIT;
    end else if (s_id) begin
      st_nxt.op    = OP_ID;
      st_nxt.idc   = '0;
      st_nxt.phase = PH_IDDATA;
    end else if (w_rdy) begin
      if (st_cur.op == OP_READ) begin
        st_nxt.phase = PH_RDATA;
      end else if (st_cur.op == OP_WRITE) begin
        if (st_cur.left == 32'd0) begin
          st_nxt.phase = PH_IDLE;
        end else begin
          st_nxt.col   = '0;
          st_nxt.page  = page_inc;
          st_nxt.phase = PH_WDATA;
        end
      end else begin
        st_nxt.left = left_blk;
        if (left_blk == 32'd0) begin
          st_nxt.phase = PH_IDLE;
        end else begin
          st_nxt.page = st_cur.page + BLOCK_PAGES;
        end
      end
    end else if (r_dat) begin
      st_nxt.left = left_dec;
      st_nxt.col  = st_cur.col + COL_W'(1);
      if (left_dec == 32'd0) begin
        st_nxt.phase = PH_IDLE;
      end else if (col_wrap) begin
        st_nxt.col   = '0;
        st_nxt.page  = page_inc;
        st_nxt.phase = PH_WAIT;
      end
    end else if (w_dat) begin
      st_nxt.left = left_dec;
      st_nxt.col  = st_cur.col + COL_W'(1);
      if (left_dec == 32'd0 || col_wrap) begin
        st_nxt.phase = PH_WAIT;
      end
    end else if (i_dat) begin
      if (id_end) begin
        st_nxt.idc   = '0;
        st_nxt.phase = PH_IDLE;
      end else begin
        st_nxt.idc = idc_inc[IDC_W-1:0];
      end
    end
  end

  assign col_ext = 16'(st_nxt.col);

  // result batch; address bytes use the updated column and row
  always_comb begin
    logic [CNT_W-1:0] n;
    n   = '0;
    res = '0;
    if (s_rd) begin
      res[n] = '{K_EN, 8'd0}; n = n + 1'b1;
      if (len_zero) begin
        res[n] = '{K_DIS, 8'd0};  n = n + 1'b1;
        res[n] = '{K_DONE, 8'd0}; n = n + 1'b1;
      end else begin
        res[n] = '{K_CMD, CMD_READ1};          n = n + 1'b1;
        res[n] = '{K_ADDR, col_ext[7:0]};      n = n + 1'b1;
        res[n] = '{K_ADDR, col_ext[15:8]};     n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[7:0]};  n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[15:8]}; n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[23:16]}; n = n + 1'b1;
        res[n] = '{K_CMD, CMD_READ2};          n = n + 1'b1;
        res[n] = '{K_WAIT, 8'd0};              n = n + 1'b1;
      end
    end else if (s_wr) begin
      res[n] = '{K_EN, 8'd0};                n = n + 1'b1;
      res[n] = '{K_CMD, CMD_PROG1};          n = n + 1'b1;
      res[n] = '{K_ADDR, col_ext[7:0]};      n = n + 1'b1;
      res[n] = '{K_ADDR, col_ext[15:8]};     n = n + 1'b1;
      res[n] = '{K_ADDR, st_nxt.page[7:0]};  n = n + 1'b1;
      res[n] = '{K_ADDR, st_nxt.page[15:8]}; n = n + 1'b1;
      res[n] = '{K_ADDR, st_nxt.page[23:16]}; n = n + 1'b1;
      if (len_zero) begin
        res[n] = '{K_CMD, CMD_PROG2}; n = n + 1'b1;
        res[n] = '{K_WAIT, 8'd0};     n = n + 1'b1;
      end
    end else if (s_er) begin
      if (addr_mis) begin
        res[n] = '{K_ERR, ERR_ADDR}; n = n + 1'b1;
      end else if (len_mis) begin
        res[n] = '{K_ERR, ERR_LEN}; n = n + 1'b1;
      end else if (len_zero) begin
        res[n] = '{K_DONE, 8'd0}; n = n + 1'b1;
      end else begin
        res[n] = '{K_EN, 8'd0};                n = n + 1'b1;
        res[n] = '{K_CMD, CMD_ERASE1};         n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[7:0]};  n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[15:8]}; n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[23:16]}; n = n + 1'b1;
        res[n] = '{K_CMD, CMD_ERASE2};         n = n + 1'b1;
        res[n] = '{K_WAIT, 8'd0};              n = n + 1'b1;
      end
    end else if (s_id) begin
      res[n] = '{K_EN, 8'd0};       n = n + 1'b1;
      res[n] = '{K_CMD, CMD_RDID};  n = n + 1'b1;
      res[n] = '{K_ADDR, ADDR_ID};  n = n + 1'b1;
      res[n] = '{K_STROBE, 8'd0};   n = n + 1'b1;
    end else if (w_rdy) begin
      if (st_cur.op == OP_READ) begin
        res[n] = '{K_STROBE, 8'd0}; n = n + 1'b1;
      end else if (st_cur.phase == st_nxt.phase || st_nxt.phase == PH_WDATA) begin
        // another page to program or another block to erase
        if (st_cur.op == OP_WRITE) begin
          res[n] = '{K_CMD, CMD_PROG1};      n = n + 1'b1;
          res[n] = '{K_ADDR, col_ext[7:0]};  n = n + 1'b1;
          res[n] = '{K_ADDR, col_ext[15:8]}; n = n + 1'b1;
        end else begin
          res[n] = '{K_CMD, CMD_ERASE1};     n = n + 1'b1;
        end
        res[n] = '{K_ADDR, st_nxt.page[7:0]};   n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[15:8]};  n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[23:16]}; n = n + 1'b1;
        if (st_cur.op != OP_WRITE) begin
          res[n] = '{K_CMD, CMD_ERASE2}; n = n + 1'b1;
          res[n] = '{K_WAIT, 8'd0};      n = n + 1'b1;
        end
      end else begin
        res[n] = '{K_DIS, 8'd0};  n = n + 1'b1;
        res[n] = '{K_DONE, 8'd0}; n = n + 1'b1;
      end
    end else if (r_dat) begin
      res[n] = '{K_HOST, data}; n = n + 1'b1;
      if (left_dec == 32'd0) begin
        res[n] = '{K_DIS, 8'd0};  n = n + 1'b1;
        res[n] = '{K_DONE, 8'd0}; n = n + 1'b1;
      end else if (col_wrap) begin
        res[n] = '{K_CMD, CMD_READ1};           n = n + 1'b1;
        res[n] = '{K_ADDR, col_ext[7:0]};       n = n + 1'b1;
        res[n] = '{K_ADDR, col_ext[15:8]};      n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[7:0]};   n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[15:8]};  n = n + 1'b1;
        res[n] = '{K_ADDR, st_nxt.page[23:16]}; n = n + 1'b1;
        res[n] = '{K_CMD, CMD_READ2};           n = n + 1'b1;
        res[n] = '{K_WAIT, 8'd0};               n = n + 1'b1;
      end else begin
        res[n] = '{K_STROBE, 8'd0}; n = n + 1'b1;
      end
    end else if (w_dat) begin
      res[n] = '{K_WDATA, data}; n = n + 1'b1;
      if (left_dec == 32'd0 || col_wrap) begin
        res[n] = '{K_CMD, CMD_PROG2}; n = n + 1'b1;
        res[n] = '{K_WAIT, 8'd0};     n = n + 1'b1;
      end
    end else if (i_dat) begin
      res[n] = '{K_HOST, data}; n = n + 1'b1;
      if (id_end) begin
        res[n] = '{K_DIS, 8'd0};  n = n + 1'b1;
        res[n] = '{K_DONE, 8'd0}; n = n + 1'b1;
      end else begin
        res[n] = '{K_STROBE, 8'd0}; n = n + 1'b1;
      end
    end else begin
      res[n] = '{K_ERR, ERR_PHASE}; n = n + 1'b1;
    end
    res_cnt = n;
  end

endmodule
